// ===== design/xlau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xlau_pkg
// Shared types, constants and keystream helpers for the archive unpacker.
// ----------------------------------------------------------------------------
package xlau_pkg;

   localparam int unsigned MAX_NAME_LEN = 511;
   localparam int unsigned NAME_REM_W   = 10;

   localparam logic [31:0] KEY_RESET = 32'hDEAD_CAFE;
   localparam logic [31:0] HDR_WORD0 = 32'h5353_4752;
   localparam logic [31:0] HDR_WORD1 = 32'h0100_4441;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_NAMELEN = 3'd1,
      PH_NAME    = 3'd2,
      PH_SIZE    = 3'd3,
      PH_DATA    = 3'd4,
      PH_HALT    = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NAME_CHAR  = 3'd0,
      KIND_ENTRY_SIZE = 3'd1,
      KIND_DATA_BYTE  = 3'd2,
      KIND_BAD_HEADER = 3'd3,
      KIND_NAME_LONG  = 3'd4,
      KIND_CLEAN_END  = 3'd5,
      KIND_TRUNCATED  = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] value;
      logic        last;
   } result_type;

   // Advance the keystream: key * 7 + 3, modulo 2^32.
   function automatic logic [31:0] next_key(input logic [31:0] k);
      return (k << 3) - k + 32'd3;
   endfunction

   // Expected header byte at position 0..7 (two little-endian words).
   function automatic logic [7:0] header_byte(input logic [2:0] pos);
      logic [63:0] hdr;
      hdr = {HDR_WORD1, HDR_WORD0};
      return hdr[{pos, 3'b000} +: 8];
   endfunction

endpackage

// ===== design/xor_lcg_archive_unpacker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_lcg_archive_unpacker
// Streaming decryptor and parser for an XOR/LCG-encrypted archive.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one archive byte per item. req_tuser flags the first byte
//          of an archive (parsing restarts at the header, key reloads from
//          initial_key); req_tlast flags the final byte.
//   rsp_*  carries decrypted results: tuser is the result kind, tdata the
//          name char, entry size or data byte (zero for status kinds), tlast
//          marks the final name char or data byte of an entry.
//   csr_*  writes initial_key; it takes effect at the next archive start.
//          Write only while the block is idle.
// Results: a result is registered and shows on rsp in the cycle after its
//   item is accepted when no older result waits ahead of it in the queue.
// Throughput: one byte per cycle while the result queue has two free entries.
//   The parse state and key update sit in one stage between the input
//   handshake and a three-entry result queue; an item that ends an archive
//   may produce two results, which can hold req_tready low until one is taken.
// Reset: the queue empties, parsing waits for the header and initial_key
//   returns to 0xDEADCAFE.
// Stall: when rsp_tready is low the queue fills; req_tready drops once fewer
//   than two free entries remain, so no result is lost.
// ----------------------------------------------------------------------------
module xor_lcg_archive_unpacker
   import xlau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] archive_byte
   input  logic        req_tuser,   // [0] start_of_archive
   input  logic        req_tlast,   // end_of_archive
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast,   // last_of_run
   // configuration
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   // ---------------------------------------------------------------------
   // Parse state
   // ---------------------------------------------------------------------
   logic [31:0]           init_key_ff;
   phase_type             phase_ff,    phase_in;
   logic [2:0]            cnt_ff,      cnt_in;      // byte within header/word
   logic [23:0]           word_ff,     word_in;     // low three bytes collected
   logic [31:0]           ikey_ff,     ikey_in;     // index keystream
   logic [31:0]           dkey_ff,     dkey_in;     // data keystream
   logic [1:0]            lane_ff,     lane_in;
   logic [NAME_REM_W-1:0] name_rem_ff, name_rem_in;
   logic [31:0]           data_rem_ff, data_rem_in;
   logic                  hdr_bad_ff,  hdr_bad_in;

   // Result queue: entry 0 is the head shown on rsp.
   result_type            q_ff [3];
   result_type            q_in [3];
   logic [1:0]            count_ff, count_in;

   logic       accept;
   logic       pop;
   result_type res0, res1;
   logic       res0_vld, res1_vld;

   // Working copies of the state after an optional restart.
   phase_type             cur_phase;
   logic [2:0]            cur_cnt;
   logic [23:0]           cur_word;
   logic [31:0]           cur_ikey, cur_dkey;
   logic [1:0]            cur_lane;
   logic [NAME_REM_W-1:0] cur_name_rem;
   logic [31:0]           cur_data_rem;
   logic                  cur_bad;

   logic [31:0] full_word;
   logic [31:0] dec_word;
   logic [7:0]  dec_char;
   logic        bad_now;

   assign accept     = req_tvalid & req_tready;
   assign pop        = rsp_tvalid & rsp_tready;
   assign req_tready = (count_ff <= 2'd1);

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = q_ff[0].value;
   assign rsp_tuser  = q_ff[0].kind;
   assign rsp_tlast  = q_ff[0].last;

   // ---------------------------------------------------------------------
   // Byte processing
   // ---------------------------------------------------------------------
   always_comb begin
      // restart before the byte is used when it opens an archive
      if (req_tuser) begin
         cur_phase    = PH_HEADER;
         cur_cnt      = '0;
         cur_word     = '0;
         cur_ikey     = init_key_ff;
         cur_dkey     = '0;
         cur_lane     = '0;
         cur_name_rem = '0;
         cur_data_rem = '0;
         cur_bad      = 1'b0;
      end else begin
         cur_phase    = phase_ff;
         cur_cnt      = cnt_ff;
         cur_word     = word_ff;
         cur_ikey     = ikey_ff;
         cur_dkey     = dkey_ff;
         cur_lane     = lane_ff;
         cur_name_rem = name_rem_ff;
         cur_data_rem = data_rem_ff;
         cur_bad      = hdr_bad_ff;
      end

      phase_in    = cur_phase;
      cnt_in      = cur_cnt;
      word_in     = cur_word;
      ikey_in     = cur_ikey;
      dkey_in     = cur_dkey;
      lane_in     = cur_lane;
      name_rem_in = cur_name_rem;
      data_rem_in = cur_data_rem;
      hdr_bad_in  = cur_bad;

      res0     = '{kind: KIND_NAME_CHAR, value: 32'd0, last: 1'b0};
      res1     = '{kind: KIND_CLEAN_END, value: 32'd0, last: 1'b0};
      res0_vld = 1'b0;
      res1_vld = 1'b0;

      full_word = {req_tdata, cur_word};
      dec_word  = full_word ^ cur_ikey;
      dec_char  = '0;
      bad_now   = cur_bad | (header_byte(cur_cnt) != req_tdata);

      unique case (cur_phase)
         PH_HEADER: begin
            hdr_bad_in = bad_now;
            cnt_in     = cur_cnt + 3'd1;
            if (cur_cnt == 3'd7) begin
               if (bad_now) begin
                  res0     = '{kind: KIND_BAD_HEADER, value: 32'd0, last: 1'b0};
                  res0_vld = 1'b1;
                  phase_in = PH_HALT;
               end else begin
                  phase_in = PH_NAMELEN;
               end
            end
         end
         PH_NAMELEN, PH_SIZE: begin
            if (cur_cnt[1:0] == 2'd3) begin
               // word complete: decrypt, advance the index key
               ikey_in = next_key(cur_ikey);
               word_in = '0;
               cnt_in  = '0;
               if (cur_phase == PH_NAMELEN) begin
                  if (dec_word > 32'(MAX_NAME_LEN)) begin
                     res0     = '{kind: KIND_NAME_LONG, value: 32'd0, last: 1'b0};
                     res0_vld = 1'b1;
                     phase_in = PH_HALT;
                  end else if (dec_word == 32'd0) begin
                     phase_in = PH_SIZE;
                  end else begin
                     name_rem_in = dec_word[NAME_REM_W-1:0];
                     phase_in    = PH_NAME;
                  end
               end else begin
                  dkey_in  = next_key(cur_ikey);
                  lane_in  = '0;
                  res0     = '{kind: KIND_ENTRY_SIZE, value: dec_word, last: 1'b0};
                  res0_vld = 1'b1;
                  if (dec_word == 32'd0) begin
                     phase_in = PH_NAMELEN;
                  end else begin
                     data_rem_in = dec_word;
                     phase_in    = PH_DATA;
                  end
               end
            end else begin
               word_in[{cur_cnt[1:0], 3'b000} +: 8] = req_tdata;
               cnt_in = cur_cnt + 3'd1;
            end
         end
         PH_NAME: begin
            dec_char = req_tdata ^ cur_ikey[7:0];
            if (dec_char == CHAR_BACKSLASH) begin
               dec_char = CHAR_SLASH;
            end
            ikey_in     = next_key(cur_ikey);
            name_rem_in = cur_name_rem - NAME_REM_W'(1);
            res0        = '{kind: KIND_NAME_CHAR, value: {24'd0, dec_char},
                            last: (cur_name_rem == NAME_REM_W'(1))};
            res0_vld    = 1'b1;
            if (cur_name_rem == NAME_REM_W'(1)) begin
               phase_in = PH_SIZE;
            end
         end
         PH_DATA: begin
            dec_char    = req_tdata ^ cur_dkey[{cur_lane, 3'b000} +: 8];
            lane_in     = cur_lane + 2'd1;
            if (cur_lane == 2'd3) begin
               dkey_in = next_key(cur_dkey);
            end
            data_rem_in = cur_data_rem - 32'd1;
            res0        = '{kind: KIND_DATA_BYTE, value: {24'd0, dec_char},
                            last: (cur_data_rem == 32'd1)};
            res0_vld    = 1'b1;
            if (cur_data_rem == 32'd1) begin
               phase_in = PH_NAMELEN;
            end
         end
         default: begin
            // halted: drop the byte
         end
      endcase

      // end of archive: clean only on a name-length word boundary
      if (req_tlast && (phase_in != PH_HALT)) begin
         if ((phase_in == PH_NAMELEN) && (cnt_in == 3'd0)) begin
            res1 = '{kind: KIND_CLEAN_END, value: 32'd0, last: 1'b0};
         end else begin
            res1 = '{kind: KIND_TRUNCATED, value: 32'd0, last: 1'b0};
         end
         res1_vld = 1'b1;
         phase_in = PH_HALT;
      end
   end

   // ---------------------------------------------------------------------
   // Result queue: shift on pop, append up to two results on accept
   // ---------------------------------------------------------------------
   always_comb begin
      logic [1:0] base;
      logic [1:0] slot1;
      q_in = q_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         q_in[1] = q_ff[2];
      end
      base  = count_ff - {1'b0, pop};
      slot1 = base + {1'b0, res0_vld};
      if (accept && res0_vld) begin
         q_in[base] = res0;
      end
      if (accept && res1_vld) begin
         q_in[slot1] = res1;
      end
      count_in = base;
      if (accept) begin
         count_in = base + {1'b0, res0_vld} + {1'b0, res1_vld};
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         init_key_ff <= KEY_RESET;
         phase_ff    <= PH_HEADER;
         cnt_ff      <= '0;
         word_ff     <= '0;
         ikey_ff     <= KEY_RESET;
         dkey_ff     <= '0;
         lane_ff     <= '0;
         name_rem_ff <= '0;
         data_rem_ff <= '0;
         hdr_bad_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_wr_en) begin
            init_key_ff <= csr_wr_data;
         end
         // hold state unless a byte is taken
         if (accept) begin
            phase_ff    <= phase_in;
            cnt_ff      <= cnt_in;
            word_ff     <= word_in;
            ikey_ff     <= ikey_in;
            dkey_ff     <= dkey_in;
            lane_ff     <= lane_in;
            name_rem_ff <= name_rem_in;
            data_rem_ff <= data_rem_in;
            hdr_bad_ff  <= hdr_bad_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3 || !req_tready)
      else $error("result queue full while input is ready");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_BAD_HEADER || rsp_tuser == KIND_NAME_LONG ||
       rsp_tuser == KIND_CLEAN_END || rsp_tuser == KIND_TRUNCATED))
      |-> (rsp_tdata == 32'd0 && !rsp_tlast))
      else $error("status result carries data or last flag");

   a_name_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_NAME) |-> (name_rem_ff != '0))
      else $error("name phase with no characters left");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (data_rem_ff != 32'd0))
      else $error("data phase with no bytes left");

endmodule

// ===== test/xor_lcg_archive_unpacker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_lcg_archive_unpacker_test
// Self-checking bench for the streaming archive unpacker. Encrypted archives
// are built on the fly (good and corrupt headers, empty and long names,
// empty, short and huge entries, clean and truncated ends, restarts), pushed
// through the byte stream with random gaps and result stalls, and every
// result is compared against a cycle-free model of the decryption.
// ----------------------------------------------------------------------------
import xlau_pkg::*;

// Keystream step: key * 7 + 3, wrapping at 32 bits.
function automatic logic [31:0] key_advance(input logic [31:0] k);
   return k * 32'd7 + 32'd3;
endfunction

class archive_scoreboard;
   logic [31:0]  key_init;
   phase_type    phase;
   logic [2:0]   byte_pos;
   logic [31:0]  word_acc;
   logic [31:0]  index_key;
   logic [31:0]  data_key;
   logic [1:0]   lane;
   logic [9:0]   name_left;
   logic [31:0]  size_left;
   bit           header_bad;
   result_type   pending_results[$];
   int unsigned  n_checked;
   int unsigned  n_errors;
   int unsigned  kind_seen[8];

   function new();
      key_init  = KEY_RESET;
      n_checked = 0;
      n_errors  = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      restart();
   endfunction

   function void restart();
      phase      = PH_HEADER;
      byte_pos   = 3'd0;
      word_acc   = 32'd0;
      index_key  = key_init;
      data_key   = 32'd0;
      lane       = 2'd0;
      name_left  = 10'd0;
      size_left  = 32'd0;
      header_bad = 1'b0;
   endfunction

   function void write_key(input logic [31:0] k);
      key_init = k;
   endfunction

   function void add_result(input kind_type k, input logic [31:0] v, input logic l);
      result_type r;
      r.kind  = k;
      r.value = v;
      r.last  = l;
      pending_results.push_back(r);
   endfunction

   // Shift one byte into the word; true once four bytes are in.
   function bit gather(input logic [7:0] b);
      word_acc = word_acc | ({24'd0, b} << {byte_pos[1:0], 3'b000});
      byte_pos = byte_pos + 3'd1;
      if (byte_pos == 3'd4) begin
         byte_pos = 3'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Decrypt one accepted archive byte and queue what it must produce.
   function void note_byte(input logic [7:0] b, input logic sos, input logic eoa);
      logic [63:0] hdr;
      logic [31:0] w;
      logic [7:0]  c;
      if (sos) restart();
      case (phase)
         PH_HEADER: begin
            hdr = {HDR_WORD1, HDR_WORD0};
            if (hdr[{byte_pos, 3'b000} +: 8] != b) header_bad = 1'b1;
            byte_pos = byte_pos + 3'd1;
            if (byte_pos == 3'd0) begin
               if (header_bad) begin
                  add_result(KIND_BAD_HEADER, 32'd0, 1'b0);
                  phase = PH_HALT;
               end else begin
                  phase = PH_NAMELEN;
               end
            end
         end
         PH_NAMELEN: begin
            if (gather(b)) begin
               w         = word_acc ^ index_key;
               index_key = key_advance(index_key);
               word_acc  = 32'd0;
               if (w > MAX_NAME_LEN) begin
                  add_result(KIND_NAME_LONG, 32'd0, 1'b0);
                  phase = PH_HALT;
               end else if (w == 32'd0) begin
                  phase = PH_SIZE;
               end else begin
                  name_left = w[9:0];
                  phase     = PH_NAME;
               end
            end
         end
         PH_NAME: begin
            c         = b ^ index_key[7:0];
            index_key = key_advance(index_key);
            if (c == CHAR_BACKSLASH) c = CHAR_SLASH;
            name_left = name_left - 10'd1;
            add_result(KIND_NAME_CHAR, {24'd0, c}, name_left == 10'd0);
            if (name_left == 10'd0) phase = PH_SIZE;
         end
         PH_SIZE: begin
            if (gather(b)) begin
               w         = word_acc ^ index_key;
               index_key = key_advance(index_key);
               word_acc  = 32'd0;
               data_key  = index_key;
               lane      = 2'd0;
               add_result(KIND_ENTRY_SIZE, w, 1'b0);
               if (w == 32'd0) begin
                  phase = PH_NAMELEN;
               end else begin
                  size_left = w;
                  phase     = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            c    = b ^ data_key[{lane, 3'b000} +: 8];
            lane = lane + 2'd1;
            if (lane == 2'd0) data_key = key_advance(data_key);
            size_left = size_left - 32'd1;
            add_result(KIND_DATA_BYTE, {24'd0, c}, size_left == 32'd0);
            if (size_left == 32'd0) phase = PH_NAMELEN;
         end
         default: ;
      endcase
      if (eoa && phase != PH_HALT) begin
         if (phase == PH_NAMELEN && byte_pos == 3'd0)
            add_result(KIND_CLEAN_END, 32'd0, 1'b0);
         else
            add_result(KIND_TRUNCATED, 32'd0, 1'b0);
         phase = PH_HALT;
      end
   endfunction

   function void flag(input string msg);
      if (n_errors < 10) $display("ERROR: %s", msg);
      n_errors++;
   endfunction

   function void check_result(input logic [2:0] kind, input logic [31:0] value,
                              input logic last);
      result_type exp;
      n_checked++;
      kind_seen[kind]++;
      if (pending_results.size() == 0) begin
         flag($sformatf("unexpected result: kind %0d value 0x%08h last %0d",
                        kind, value, last));
         return;
      end
      exp = pending_results.pop_front();
      if (exp.kind != kind || exp.value != value || exp.last != last)
         flag($sformatf({"expected kind %0d value 0x%08h last %0d, ",
                         "got kind %0d value 0x%08h last %0d"},
                        exp.kind, exp.value, exp.last, kind, value, last));
   endfunction
endclass

module xor_lcg_archive_unpacker_test;

   localparam int STALL_LIMIT     = 2000;  // cycles without any handshake
   localparam int ITEMS_PER_PHASE = 120;
   localparam int KEY_PHASES      = 5;
   localparam int CALM_AFTER      = 480;   // no idling past this many items

   typedef struct {
      logic [7:0] data;
      logic       sos;
      logic       eoa;
   } arc_byte_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'd0;   // [7:0] archive_byte
   logic        req_tuser   = 1'b0;   // [0] start_of_archive
   logic        req_tlast   = 1'b0;   // end_of_archive
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;            // [31:0] value
   logic [2:0]  rsp_tuser;            // [2:0] kind
   logic        rsp_tlast;            // last_of_run
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = 32'd0;

   archive_scoreboard sb;
   arc_byte_type      arc_q[$];
   logic [31:0]       enc_key;
   bit                idle_on = 1'b0;
   bit                max_name_done = 1'b0;
   int unsigned       items_sent = 0;
   int                stall_left = 0;
   int                quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   xor_lcg_archive_unpacker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Result side: drop rsp_tready in random stall bursts while idling is on.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check every accepted result against the oldest expectation. Values read
   // here are the ones from before this edge, since all drives are nonblocking.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Offer one byte, optionally after a random gap, and hold it until taken.
   task automatic send_item(input logic [7:0] b, input logic sos, input logic eoa);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tdata  <= b;
      req_tuser  <= sos;
      req_tlast  <= eoa;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b, sos, eoa);
      items_sent++;
   endtask

   // Drop valid and wait until every expected result is back, plus the
   // pipeline depth so an item without results has settled too.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_initial_key(input logic [31:0] k);
      csr_wr_data <= k;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      sb.write_key(k);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic put_byte(input logic [7:0] b);
      arc_byte_type a;
      a.data = b;
      a.sos  = 1'b0;
      a.eoa  = 1'b0;
      arc_q.push_back(a);
   endtask

   task automatic put_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++) put_byte(w[8*i +: 8]);
   endtask

   // Header bytes; corrupt flips one random bit somewhere in the eight.
   task automatic put_header(input bit corrupt);
      logic [63:0] hdr;
      int          flip;
      hdr = {HDR_WORD1, HDR_WORD0};
      if (corrupt) begin
         flip = $urandom_range(0, 63);
         hdr[flip] = ~hdr[flip];
      end
      for (int i = 0; i < 8; i++) put_byte(hdr[8*i +: 8]);
   endtask

   // Encrypt one entry with the running index key. data_count may be less
   // than size to leave the entry unfinished.
   task automatic put_entry(input logic [31:0] name_len, input logic [31:0] size,
                            input int data_count, input bit all_backslash);
      logic [7:0] ch;
      put_word(name_len ^ enc_key);
      enc_key = key_advance(enc_key);
      for (int i = 0; i < name_len; i++) begin
         ch = (all_backslash || $urandom_range(0, 3) == 0) ? CHAR_BACKSLASH : 8'($urandom);
         put_byte(ch ^ enc_key[7:0]);
         enc_key = key_advance(enc_key);
      end
      put_word(size ^ enc_key);
      enc_key = key_advance(enc_key);
      for (int i = 0; i < data_count; i++) put_byte(8'($urandom));
   endtask

   task automatic send_archive();
      arc_q[0].sos = 1'b1;
      foreach (arc_q[i]) send_item(arc_q[i].data, arc_q[i].sos, arc_q[i].eoa);
   endtask

   // One random archive: mostly well formed, some with a corrupt header, an
   // oversized name, a huge entry, a cut-off end, or left open for a restart.
   task automatic run_archive();
      int          sel;
      int          entries;
      int          ending;
      int          cut;
      int          cnt;
      int          long_at;
      logic [31:0] nl;
      logic [31:0] sz;
      arc_q.delete();
      long_at = -1;
      enc_key = sb.key_init;
      idle_on = (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      sel     = $urandom_range(0, 19);
      put_header(sel == 0);
      if (sel != 0) begin
         entries = $urandom_range(1, 3);
         for (int e = 0; e < entries; e++) begin
            if (sel == 1 && e == entries - 1) begin
               // name length just past the limit, or far past it
               case ($urandom_range(0, 2))
                  0:       nl = MAX_NAME_LEN + 1;
                  1:       nl = 32'hFFFF_FFFF;
                  default: nl = $urandom | 32'h0000_0200;
               endcase
               put_word(nl ^ enc_key);
               enc_key = key_advance(enc_key);
            end else begin
               nl = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
               if (!max_name_done && sel == 3 && items_sent > 200) begin
                  // longest legal name; the archive is cut a few chars in
                  nl            = MAX_NAME_LEN;
                  max_name_done = 1'b1;
                  long_at       = arc_q.size();
               end
               if (sel == 2 && e == entries - 1) begin
                  // huge entry: a few data bytes, then the archive ends
                  sz  = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'd16);
                  cnt = $urandom_range(0, 6);
               end else begin
                  sz  = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 10));
                  cnt = sz;
               end
               put_entry(nl, sz, cnt, 1'b0);
            end
         end
      end
      ending = $urandom_range(0, 9);
      if (long_at >= 0) begin
         cut   = long_at + 4 + $urandom_range(0, 7);
         arc_q = arc_q[0:cut];
         arc_q[cut].eoa = 1'b1;
      end else if (ending < 6 || ending == 9 || sel == 2) begin
         arc_q[arc_q.size() - 1].eoa = 1'b1;
      end else if (ending < 8) begin
         cut = $urandom_range(0, arc_q.size() - 1);
         arc_q = arc_q[0:cut];
         arc_q[cut].eoa = 1'b1;
      end
      send_archive();
      // stray bytes after a halt must be ignored
      if (ending == 9 || sel <= 1)
         repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0, 1'($urandom));
   endtask

   initial begin
      logic [31:0] key_set[KEY_PHASES];
      int          errors;
      sb = new();
      key_set[0] = KEY_RESET;
      key_set[1] = 32'h0000_0000;
      key_set[2] = 32'hFFFF_FFFF;
      key_set[3] = $urandom;
      key_set[4] = $urandom;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: corrupt header with the end flag on its last byte, a stray
      // byte while halted, then one short entry whose name is a backslash and
      // whose last data byte also ends the archive.
      arc_q.delete();
      enc_key = sb.key_init;
      put_header(1'b1);
      arc_q[7].eoa = 1'b1;
      send_archive();
      send_item(8'hA5, 1'b0, 1'b1);
      arc_q.delete();
      enc_key = sb.key_init;
      put_header(1'b0);
      put_entry(32'd1, 32'd1, 1, 1'b1);
      arc_q[arc_q.size() - 1].eoa = 1'b1;
      send_archive();

      // Random archives under a series of key settings, reset value first.
      for (int ph = 0; ph < KEY_PHASES; ph++) begin
         if (ph > 0) begin
            drain();
            write_initial_key(key_set[ph]);
         end
         while (items_sent < (ph + 1) * ITEMS_PER_PHASE) run_archive();
      end

      idle_on = 1'b0;
      drain();
      repeat (10) @(posedge clock);

      if (sb.pending_results.size() != 0)
         sb.flag($sformatf("%0d expected results never arrived",
                           sb.pending_results.size()));
      errors = sb.n_errors;
      $display("Run covered %0d archive bytes over %0d key settings, %0d results checked",
               items_sent, KEY_PHASES, sb.n_checked);
      $display({"By kind: %0d name, %0d size, %0d data, %0d bad hdr, ",
                "%0d long name, %0d clean, %0d trunc"},
               sb.kind_seen[KIND_NAME_CHAR], sb.kind_seen[KIND_ENTRY_SIZE],
               sb.kind_seen[KIND_DATA_BYTE], sb.kind_seen[KIND_BAD_HEADER],
               sb.kind_seen[KIND_NAME_LONG], sb.kind_seen[KIND_CLEAN_END],
               sb.kind_seen[KIND_TRUNCATED]);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Mismatches: %0d", errors);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/xlau_pkg.sv
design/xor_lcg_archive_unpacker.sv
test/xor_lcg_archive_unpacker_test.sv
